// File: rtl/core/itt_pkg.sv
// itt_pkg: shared types, codes and widths for the interval timer table
// depends on nothing; every other file of the block uses it
package itt_pkg;

   localparam int TIMERS_DEFAULT = 16;
   localparam int CMD_W    = 3;
   localparam int ID_W     = 16;
   localparam int PERIOD_W = 32;
   localparam int TIME_W   = 48;
   localparam int STAMP_W  = 32;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 49;

   localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SET     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_EXECUTE = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_DECIDE
   } state_type;

   typedef enum logic [2:0] {
      RK_ADD,
      RK_OK,
      RK_ABSENT,
      RK_NONE,
      RK_TIMEOUT,
      RK_FIRE,
      RK_CLOSE
   } rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         scan_clear;
      logic         scan_step;
      logic         do_add;
      logic         do_cancel;
      logic         do_resched;
      logic         do_purge;
      logic         do_fire;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             found;
      logic             best_cancelled;
      logic             best_due;
      logic             scan_last;
      logic             rsp_busy;
   } ctrl_stat_type;

endpackage

// File: rtl/core/itt_if.sv
// itt_req_if and itt_rsp_if: valid/ready channels of the timer table
// depends on itt_pkg for field widths
interface itt_req_if;
   logic                          valid;
   logic                          ready;
   logic [itt_pkg::CMD_W-1:0]     command;
   logic [itt_pkg::ID_W-1:0]      target_id;
   logic [itt_pkg::PERIOD_W-1:0]  interval;
   logic [itt_pkg::TIME_W-1:0]    now;
   modport source (output valid, command, target_id, interval, now, input ready);
   modport sink   (input valid, command, target_id, interval, now, output ready);
endinterface

interface itt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [itt_pkg::STATUS_W-1:0]     status;
   logic signed [itt_pkg::VALUE_W-1:0] value;
   logic                             fired;
   logic                             last;
   modport source (output valid, status, value, fired, last, input ready);
   modport sink   (input valid, status, value, fired, last, output ready);
endinterface

// File: rtl/core/itt_ctrl.sv
// itt_ctrl: command sequencer of the timer table
// depends on itt_pkg; drives itt_dpath through ctrl_cmd_type
module itt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  itt_pkg::ctrl_stat_type stat,
   output itt_pkg::ctrl_cmd_type  cmd
);
   import itt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rsp_kind = RK_OK;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.cmd == CMD_ADD) begin
               if (!stat.rsp_busy) begin
                  cmd.do_add   = 1'b1;
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_kind = RK_ADD;
                  state_in     = S_IDLE;
               end
            end else if (stat.cmd == CMD_CANCEL || stat.cmd == CMD_SET ||
                         stat.cmd == CMD_RESTART || stat.cmd == CMD_QUERY ||
                         stat.cmd == CMD_EXECUTE) begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end else if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RK_OK;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!stat.rsp_busy) begin
               state_in = S_IDLE;
               case (stat.cmd)
                  CMD_CANCEL: begin
                     cmd.rsp_load = 1'b1;
                     if (!stat.found || stat.best_cancelled) begin
                        cmd.rsp_kind = RK_ABSENT;
                     end else begin
                        cmd.do_cancel = 1'b1;
                        cmd.rsp_kind  = RK_OK;
                     end
                  end
                  CMD_SET, CMD_RESTART: begin
                     cmd.rsp_load = 1'b1;
                     if (!stat.found) begin
                        cmd.rsp_kind = RK_ABSENT;
                     end else begin
                        cmd.do_resched = 1'b1;
                        cmd.rsp_kind   = RK_OK;
                     end
                  end
                  CMD_QUERY: begin
                     if (!stat.found) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_kind = RK_NONE;
                     end else if (stat.best_cancelled) begin
                        cmd.do_purge   = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_in       = S_SCAN;
                     end else begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_kind = RK_TIMEOUT;
                     end
                  end
                  CMD_EXECUTE: begin
                     if (stat.found && stat.best_cancelled) begin
                        cmd.do_purge   = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_in       = S_SCAN;
                     end else if (stat.found && stat.best_due) begin
                        cmd.do_fire    = 1'b1;
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_kind   = RK_FIRE;
                        cmd.scan_clear = 1'b1;
                        state_in       = S_SCAN;
                     end else begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_kind = RK_CLOSE;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_kind = RK_OK;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: rtl/core/itt_dpath.sv
// itt_dpath: slot storage, ordered scan, scheduling and result register
// depends on itt_pkg; sequenced by itt_ctrl
module itt_dpath #(
   parameter int TIMERS = itt_pkg::TIMERS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  itt_pkg::ctrl_cmd_type            cmd,
   output itt_pkg::ctrl_stat_type           stat,
   input  logic [itt_pkg::CMD_W-1:0]        req_command,
   input  logic [itt_pkg::ID_W-1:0]         req_target_id,
   input  logic [itt_pkg::PERIOD_W-1:0]     req_interval,
   input  logic [itt_pkg::TIME_W-1:0]       req_now,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [itt_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [itt_pkg::VALUE_W-1:0] rsp_value,
   output logic                             rsp_fired,
   output logic                             rsp_last
);
   import itt_pkg::*;

   localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TIMERS - 1);

   logic                valid_ff  [TIMERS];
   logic                canc_ff   [TIMERS];
   logic                done_ff   [TIMERS];
   logic [ID_W-1:0]     ident_ff  [TIMERS];
   logic [PERIOD_W-1:0] period_ff [TIMERS];
   logic [TIME_W-1:0]   dl_ff     [TIMERS];
   logic [STAMP_W-1:0]  stamp_ff  [TIMERS];

   logic [ID_W-1:0]     id_ctr_ff;
   logic [STAMP_W-1:0]  stamp_ctr_ff;

   logic [CMD_W-1:0]    cmd_ff;
   logic [ID_W-1:0]     id_ff;
   logic [PERIOD_W-1:0] ival_ff;
   logic [TIME_W-1:0]   now_ff;

   logic [IW-1:0]       scan_ff, best_ff;
   logic                found_ff;
   logic [TIME_W-1:0]   best_dl_ff;
   logic [STAMP_W-1:0]  best_st_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic                rsp_fired_ff, rsp_last_ff;

   logic [IW-1:0]       free_idx;
   logic                full;
   logic                is_find, cand, ahead;
   logic [PERIOD_W-1:0] sched_period;
   logic [TIME_W:0]     sched_sum;
   logic [TIME_W-1:0]   sched_dl;
   logic [IW-1:0]       wr_idx;
   logic [STATUS_W-1:0] new_status;
   logic [VALUE_W-1:0]  new_value;
   logic                new_fired, new_last;
   logic [ID_W-1:0]     next_id;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      full     = 1'b1;
      for (int i = TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
            full     = 1'b0;
         end
      end
   end

   assign is_find = (cmd_ff == CMD_CANCEL) || (cmd_ff == CMD_SET) ||
                    (cmd_ff == CMD_RESTART);
   assign ahead = (dl_ff[scan_ff] < best_dl_ff) ||
                  ((dl_ff[scan_ff] == best_dl_ff) && (stamp_ff[scan_ff] < best_st_ff));
   assign cand  = valid_ff[scan_ff] && (!is_find || ident_ff[scan_ff] == id_ff) &&
                  (!found_ff || ahead);

   // saturating deadline
   assign wr_idx       = cmd.do_add ? free_idx : best_ff;
   assign sched_period = cmd.do_add || (cmd.do_resched && cmd_ff == CMD_SET) ?
                         ival_ff : period_ff[best_ff];
   assign sched_sum    = {1'b0, now_ff} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, sched_period};
   assign sched_dl     = sched_sum[TIME_W] ? '1 : sched_sum[TIME_W-1:0];
   assign next_id      = id_ctr_ff + ID_W'(1);

   always_comb begin
      new_status = ST_OK;
      new_value  = '0;
      new_fired  = 1'b0;
      new_last   = 1'b1;
      case (cmd.rsp_kind)
         RK_ADD: begin
            if (full) new_status = ST_FULL;
            else      new_value  = {{(VALUE_W - ID_W){1'b0}}, next_id};
         end
         RK_ABSENT: new_status = ST_ABSENT;
         RK_NONE:   new_value  = '1;
         RK_TIMEOUT: begin
            if (best_dl_ff > now_ff) new_value = {1'b0, best_dl_ff - now_ff};
         end
         RK_FIRE: begin
            new_value = {{(VALUE_W - ID_W){1'b0}}, ident_ff[best_ff]};
            new_fired = 1'b1;
            new_last  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         id_ff   <= req_target_id;
         ival_ff <= req_interval;
         now_ff  <= req_now;
      end
      if (cmd.scan_step && cand) begin
         best_ff    <= scan_ff;
         best_dl_ff <= dl_ff[scan_ff];
         best_st_ff <= stamp_ff[scan_ff];
      end
      if ((cmd.do_add && !full) || cmd.do_resched || cmd.do_fire) begin
         dl_ff[wr_idx]    <= sched_dl;
         stamp_ff[wr_idx] <= stamp_ctr_ff;
      end
      if (cmd.do_add && !full) begin
         ident_ff[free_idx]  <= next_id;
         period_ff[free_idx] <= ival_ff;
      end
      if (cmd.do_resched && cmd_ff == CMD_SET) period_ff[best_ff] <= ival_ff;
      if (cmd.rsp_load) begin
         rsp_status_ff <= new_status;
         rsp_value_ff  <= new_value;
         rsp_fired_ff  <= new_fired;
         rsp_last_ff   <= new_last;
      end
      if (cmd.scan_clear) scan_ff <= '0;
      else if (cmd.scan_step) scan_ff <= scan_ff + IW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMERS; i++) begin
            valid_ff[i] <= 1'b0;
            canc_ff[i]  <= 1'b0;
            done_ff[i]  <= 1'b0;
         end
         id_ctr_ff    <= '0;
         stamp_ctr_ff <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            for (int i = 0; i < TIMERS; i++) done_ff[i] <= 1'b0;
         end
         if (cmd.scan_clear) found_ff <= 1'b0;
         else if (cmd.scan_step && cand) found_ff <= 1'b1;
         if (cmd.do_add && !full) begin
            valid_ff[free_idx] <= 1'b1;
            canc_ff[free_idx]  <= 1'b0;
            id_ctr_ff          <= next_id;
         end
         if (cmd.do_cancel) canc_ff[best_ff] <= 1'b1;
         if (cmd.do_purge) begin
            valid_ff[best_ff] <= 1'b0;
            canc_ff[best_ff]  <= 1'b0;
         end
         if (cmd.do_fire) done_ff[best_ff] <= 1'b1;
         if ((cmd.do_add && !full) || cmd.do_resched || cmd.do_fire)
            stamp_ctr_ff <= stamp_ctr_ff + STAMP_W'(1);
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.cmd            = cmd_ff;
   assign stat.found          = found_ff;
   assign stat.best_cancelled = canc_ff[best_ff];
   assign stat.best_due       = !done_ff[best_ff] && !(best_dl_ff > now_ff);
   assign stat.scan_last      = (scan_ff == LAST_IDX);
   assign stat.rsp_busy       = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = $signed(rsp_value_ff);
   assign rsp_fired  = rsp_fired_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// File: rtl/core/interval_timer_table.sv
// interval_timer_table: deadline-ordered table of periodic timers
// add and unknown codes load their result from dispatch; cancel, set, restart, query
// and execute first scan every slot, then decide; each purge or firing adds a scan and
// decision, and a held result blocks the next firing until it is taken
// one request at a time: ready again in the cycle after the closing result is loaded
// reset (synchronous, active high) empties the table and clears both counters
module interval_timer_table #(
   parameter int TIMERS = itt_pkg::TIMERS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   itt_req_if.sink   req_bus,
   itt_rsp_if.source rsp_bus
);
   import itt_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencer: accepts a request, runs scans, picks the result kind
   itt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot storage, earliest-entry search and output register
   itt_dpath #(.TIMERS(TIMERS)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_command   (req_bus.command),
      .req_target_id (req_bus.target_id),
      .req_interval  (req_bus.interval),
      .req_now       (req_bus.now),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_status    (rsp_bus.status),
      .rsp_value     (rsp_bus.value),
      .rsp_fired     (rsp_bus.fired),
      .rsp_last      (rsp_bus.last)
   );

   // a firing result is never the closing one
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.fired |-> !rsp_bus.last && rsp_bus.status == ST_OK)
      else $error("firing result marked last");

   // error statuses only on single closing results
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != ST_OK |-> rsp_bus.last && !rsp_bus.fired)
      else $error("error status on non-closing result");

   // one request at a time: no accept straight after an accept
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("back-to-back request accepted");

endmodule
